// ===== rtl/zbr_pkg.sv =====
// Shared types and constants for the z-buffered triangle rasterizer.
// No dependencies.
`default_nettype none
package zbr_pkg;
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;
  localparam logic [15:0] DEPTH_FAR = 16'hFFFF;
endpackage
`default_nettype wire

// ===== rtl/zbuffer_triangle_rasterizer.sv =====
// Top level: depth and color stores in two synchronous memories, pixel walker and divider.
// Depends on zbr_pkg.
//
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_ready  | opcode, three vertices, gain, color
// out_    | output    | out_valid/out_ready| pixels_drawn, lit, rgb, depth
//
// Clear: one memory entry a cycle, over every address. Read: states S_RD, S_RDW, S_OUT.
// Draw: per pixel of the clipped box, S_EDGE, S_MUL and S_NEXT outside the triangle; inside,
// edge/depth states S_EDGE, S_MUL, S_SUM, the bit-serial depth divider and a read-modify-write.
// After reset a clearing pass over every entry runs before the first item is accepted.
// The output register holds a result until taken; no new item starts while it is full.
`default_nettype none
module zbuffer_triangle_rasterizer import zbr_pkg::*; #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_opcode,
  input  wire logic signed [15:0] in_v0_x,
  input  wire logic signed [15:0] in_v0_y,
  input  wire logic [15:0]        in_v0_depth,
  input  wire logic signed [15:0] in_v1_x,
  input  wire logic signed [15:0] in_v1_y,
  input  wire logic [15:0]        in_v1_depth,
  input  wire logic signed [15:0] in_v2_x,
  input  wire logic signed [15:0] in_v2_y,
  input  wire logic [15:0]        in_v2_depth,
  input  wire logic [8:0]         in_light_gain,
  input  wire logic [23:0]        in_base_rgb,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             out_pixels_drawn,
  output logic                    out_pixel_lit,
  output logic [23:0]             out_pixel_rgb,
  output logic [15:0]             out_pixel_depth
);
  localparam int XW = $clog2(SCREEN_WIDTH);
  localparam int YW = $clog2(SCREEN_HEIGHT);
  localparam int PIX = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW = $clog2(PIX);
  localparam logic [AW-1:0] LAST_ADDR = AW'(PIX - 1);
  localparam logic signed [17:0] XMAX = 18'(SCREEN_WIDTH - 1);
  localparam logic signed [17:0] YMAX = 18'(SCREEN_HEIGHT - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_BOX, S_AREA, S_EDGE, S_MUL, S_SUM, S_DIV, S_RMW, S_WB,
    S_NEXT, S_RD, S_RDW, S_OUT
  } state_t;
  state_t state_r;

  logic [15:0] depth_mem [PIX];
  logic [24:0] color_mem [PIX];
  logic [15:0] dq_r;
  logic [24:0] cq_r;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0] wdepth;
  logic [24:0] wcolor;

  always_ff @(posedge clk) begin
    if (we) begin
      depth_mem[waddr] <= wdepth;
      color_mem[waddr] <= wcolor;
    end
    dq_r <= depth_mem[raddr];
    cq_r <= color_mem[raddr];
  end

  logic signed [16:0] x0_r, y0_r, x1_r, y1_r, x2_r, y2_r;
  logic [15:0] z0_r, z1_r, z2_r;
  logic [8:0]  gain_r;
  logic [23:0] rgb_r;
  logic [1:0]  op_r;
  logic [AW-1:0] clr_r;
  logic [XW-1:0] px_r, minx_r, maxx_r;
  logic [YW-1:0] py_r, maxy_r;
  logic signed [35:0] area_r, w0_r, w1_r, w2_r;
  logic signed [53:0] m0_r, m1_r, m2_r;
  logic [55:0] num_r;
  logic [35:0] den_r;
  logic [55:0] quo_r;
  logic [36:0] rem_r;
  logic [5:0]  dcnt_r;
  logic [15:0] dep_r, drawn_r;
  logic        valid_r;
  logic [15:0] o_drawn_r, o_depth_r;
  logic        o_lit_r;
  logic [23:0] o_rgb_r;

  // box from floor(min) to ceil(max), clipped
  function automatic logic signed [17:0] fl16(input logic signed [16:0] v);
    return 18'(v >>> 4);
  endfunction
  function automatic logic signed [17:0] cl16(input logic signed [16:0] v);
    logic signed [17:0] t;
    t = 18'(v) + 18'sd15;
    return t >>> 4;
  endfunction
  function automatic logic signed [16:0] mn(input logic signed [16:0] a, b, c);
    logic signed [16:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction
  function automatic logic signed [16:0] mx(input logic signed [16:0] a, b, c);
    logic signed [16:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction
  function automatic logic [7:0] shade(input logic [7:0] ch, input logic [8:0] g);
    logic [16:0] p;
    p = 17'(ch) * 17'(g);
    return (p[16:8] > 9'd255) ? 8'hFF : p[15:8];
  endfunction

  logic signed [17:0] bminx, bmaxx, bminy, bmaxy;
  always_comb begin
    bminx = fl16(mn(x0_r, x1_r, x2_r));
    bmaxx = cl16(mx(x0_r, x1_r, x2_r));
    bminy = fl16(mn(y0_r, y1_r, y2_r));
    bmaxy = cl16(mx(y0_r, y1_r, y2_r));
    if (bminx < 0) bminx = '0;
    if (bminy < 0) bminy = '0;
    if (bmaxx > XMAX) bmaxx = XMAX;
    if (bmaxy > YMAX) bmaxy = YMAX;
  end

  logic signed [17:0] cx, cy;
  assign cx = $signed({1'b0, 17'(px_r)} <<< 4) + 18'sd8;
  assign cy = $signed({1'b0, 17'(py_r)} <<< 4) + 18'sd8;

  logic [AW-1:0] paddr;
  assign paddr = AW'(py_r * SCREEN_WIDTH) + AW'(px_r);

  logic in_rd;
  assign in_rd = (op_r == OP_READ) && (x0_r >= 0) && (x0_r <= XMAX)
                 && (y0_r >= 0) && (y0_r <= YMAX);

  logic in_tri;
  assign in_tri = (w0_r >= 0 && w1_r >= 0 && w2_r >= 0) ||
                  (w0_r <= 0 && w1_r <= 0 && w2_r <= 0);

  logic signed [55:0] sum;
  assign sum = 56'(m0_r) + 56'(m1_r) + 56'(m2_r);

  logic [36:0] rtry;
  assign rtry = {rem_r[35:0], num_r[55]};

  always_comb begin
    we = 1'b0;
    waddr = paddr;
    wdepth = dep_r;
    wcolor = {1'b1, shade(rgb_r[23:16], gain_r), shade(rgb_r[15:8], gain_r),
              shade(rgb_r[7:0], gain_r)};
    raddr = paddr;
    if (state_r == S_CLEAR) begin
      we = 1'b1;
      waddr = clr_r;
      wdepth = DEPTH_FAR;
      wcolor = '0;
    end else if (state_r == S_WB) begin
      we = (dep_r < dq_r);
    end
  end

  assign in_ready = (state_r == S_IDLE) && !valid_r;
  assign out_valid = valid_r;
  assign out_pixels_drawn = o_drawn_r;
  assign out_pixel_lit = o_lit_r;
  assign out_pixel_rgb = o_rgb_r;
  assign out_pixel_depth = o_depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (valid_r && out_ready) valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == LAST_ADDR) state_r <= S_IDLE;
        end
        S_IDLE: if (in_valid && in_ready) begin
          op_r <= in_opcode;
          x0_r <= 17'(in_v0_x); y0_r <= 17'(in_v0_y); z0_r <= in_v0_depth;
          x1_r <= 17'(in_v1_x); y1_r <= 17'(in_v1_y); z1_r <= in_v1_depth;
          x2_r <= 17'(in_v2_x); y2_r <= 17'(in_v2_y); z2_r <= in_v2_depth;
          gain_r <= in_light_gain; rgb_r <= in_base_rgb;
          drawn_r <= '0;
          o_drawn_r <= '0; o_lit_r <= 1'b0; o_rgb_r <= '0; o_depth_r <= '0;
          unique case (opcode_t'(in_opcode))
            OP_CLEAR: begin clr_r <= '0; state_r <= S_CLEAR; valid_r <= 1'b1; end
            OP_DRAW:  state_r <= S_BOX;
            OP_READ:  state_r <= S_RD;
            OP_NONE:  valid_r <= 1'b1;
          endcase
        end
        S_BOX: begin
          px_r <= XW'(bminx); minx_r <= XW'(bminx); maxx_r <= XW'(bmaxx);
          py_r <= YW'(bminy); maxy_r <= YW'(bmaxy);
          area_r <= 36'((x1_r - x0_r) * (y2_r - y0_r)) - 36'((y1_r - y0_r) * (x2_r - x0_r));
          if (z0_r == 0 || z1_r == 0 || z2_r == 0 || bminx > bmaxx || bminy > bmaxy)
            state_r <= S_OUT;
          else state_r <= S_AREA;
        end
        S_AREA: begin
          den_r <= area_r[35] ? 36'(-area_r) : 36'(area_r);
          state_r <= (area_r == 0) ? S_OUT : S_EDGE;
        end
        S_EDGE: begin
          w0_r <= 36'((x1_r - cx) * (y2_r - cy)) - 36'((y1_r - cy) * (x2_r - cx));
          w1_r <= 36'((x2_r - cx) * (y0_r - cy)) - 36'((y2_r - cy) * (x0_r - cx));
          w2_r <= 36'((x0_r - cx) * (y1_r - cy)) - 36'((y0_r - cy) * (x1_r - cx));
          state_r <= S_MUL;
        end
        S_MUL: begin
          m0_r <= w0_r * $signed({1'b0, z0_r});
          m1_r <= w1_r * $signed({1'b0, z1_r});
          m2_r <= w2_r * $signed({1'b0, z2_r});
          state_r <= in_tri ? S_SUM : S_NEXT;
        end
        S_SUM: begin
          begin
            logic signed [55:0] n;
            n = area_r[35] ? -sum : sum;
            num_r <= n[55] ? '0 : n;
          end
          rem_r <= '0; dcnt_r <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          // restoring divide, one quotient bit a cycle
          num_r <= num_r << 1;
          if (rtry >= {1'b0, den_r}) begin
            rem_r <= rtry - {1'b0, den_r};
            quo_r <= {quo_r[54:0], 1'b1};
          end else begin
            rem_r <= rtry;
            quo_r <= {quo_r[54:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == 6'd55) state_r <= S_RMW;
        end
        S_RMW: begin
          dep_r <= (quo_r[55:16] != 0) ? DEPTH_FAR : quo_r[15:0];
          state_r <= S_WB;
        end
        S_WB: begin
          if (dep_r < dq_r && drawn_r != 16'hFFFF) drawn_r <= drawn_r + 1'b1;
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          if (px_r == maxx_r) begin
            px_r <= minx_r;
            if (py_r == maxy_r) state_r <= S_OUT;
            else begin py_r <= py_r + 1'b1; state_r <= S_EDGE; end
          end else begin
            px_r <= px_r + 1'b1; state_r <= S_EDGE;
          end
        end
        S_RD: begin
          px_r <= XW'(x0_r); py_r <= YW'(y0_r);
          state_r <= S_RDW;
        end
        S_RDW: state_r <= S_OUT;
        S_OUT: begin
          if (op_r == OP_READ) begin
            o_lit_r <= in_rd ? cq_r[24] : 1'b0;
            o_rgb_r <= in_rd ? cq_r[23:0] : '0;
            o_depth_r <= in_rd ? dq_r : DEPTH_FAR;
          end else o_drawn_r <= drawn_r;
          valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // S_RDW reads the latched address; memory output is valid in S_OUT
  property p_out_hold;
    @(posedge clk) disable iff (!rst_n) (out_valid && !out_ready) |=> out_valid;
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_write_only: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_CLEAR || state_r == S_WB)) else $error("stray write");
endmodule
`default_nettype wire
